FILE: hdl/clnw_pkg.sv
// Shared constants, lookup functions and controller/datapath interface types.
`default_nettype none

package clnw_pkg;

  localparam int unsigned NumW      = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned BitCntW   = $clog2(NumW);
  localparam int unsigned InitLen   = 3;

  localparam logic [2:0] OpCmd    = 3'd0;
  localparam logic [2:0] OpData   = 3'd1;
  localparam logic [2:0] OpCursor = 3'd2;
  localparam logic [2:0] OpInt    = 3'd3;
  localparam logic [2:0] OpInit   = 3'd4;

  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdDispOn  = 8'h0E;
  localparam logic [7:0] CmdShift   = 8'h18;
  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  localparam logic [7:0] RowBase0 = 8'h80;
  localparam logic [7:0] RowBase1 = 8'hC0;
  localparam logic [7:0] RowBase2 = 8'h94;
  localparam logic [7:0] RowBase3 = 8'hD4;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = RowBase0;
      2'd1:    base = RowBase1;
      2'd2:    base = RowBase2;
      default: base = RowBase3;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CmdClear;
      2'd1:    b = CmdDispOn;
      default: b = CmdShift;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic load;     // capture the incoming request
    logic conv;     // one binary-to-BCD shift step
    logic strip;    // drop one leading zero digit
    logic push_hi;  // send high nibble of current byte
    logic push_lo;  // send low nibble and advance to next byte
  } clnw_cmd_t;

  typedef struct packed {
    logic op_ok;      // incoming op is a defined request
    logic op_is_int;  // incoming op is an integer print
    logic conv_done;  // this conversion step is the final one
    logic strip_more; // top digit is a leading zero
    logic last_byte;  // current byte is the final one of the request
    logic out_free;   // output register can take a word this cycle
  } clnw_sts_t;

endpackage

`default_nettype wire

FILE: hdl/clnw_ctrl.sv
// Request sequencer: steps conversion, zero stripping and nibble emission.
`default_nettype none

module clnw_ctrl import clnw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  clnw_sts_t sts_i,
  output clnw_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StStrip,
    StHi,
    StLo
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept;
    cmd_o.conv    = (state_q == StConv);
    cmd_o.strip   = (state_q == StStrip) && sts_i.strip_more;
    cmd_o.push_hi = (state_q == StHi) && sts_i.out_free;
    cmd_o.push_lo = (state_q == StLo) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept && sts_i.op_ok) begin
            state_q <= sts_i.op_is_int ? StConv : StHi;
          end
        end
        StConv: begin
          if (sts_i.conv_done) begin
            state_q <= StStrip;
          end
        end
        StStrip: begin
          if (!sts_i.strip_more) begin
            state_q <= StHi;
          end
        end
        StHi: begin
          if (sts_i.out_free) begin
            state_q <= StLo;
          end
        end
        StLo: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.last_byte ? StIdle : StHi;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clnw_dpath.sv
// Datapath: request registers, BCD converter, byte selection and output register.
`default_nettype none

module clnw_dpath import clnw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clnw_cmd_t          cmd_i,
  output clnw_sts_t          sts_o,
  input  logic [2:0]         op_i,
  input  logic [7:0]         byte_value_i,
  input  logic [1:0]         row_i,
  input  logic [4:0]         column_i,
  input  logic signed [31:0] number_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [3:0]         nibble_o,
  output logic               reg_select_o,
  output logic               last_o
);

  logic [2:0]         op_q;
  logic [7:0]         byte_q;
  logic [NumW-1:0]    bin_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    bcd_adj;
  logic               neg_q;
  logic [3:0]         ndig_q;
  logic [BitCntW-1:0] bitcnt_q;
  logic [1:0]         idx_q;
  logic               out_valid_q;
  logic [3:0]         nibble_q;
  logic               rs_q;
  logic               last_q;
  logic [7:0]         cur_byte;
  logic [DigitW-1:0]  top_digit;
  logic               cur_rs;
  logic               is_int;

  assign top_digit = bcd_q[BcdW-1 -: DigitW];
  assign is_int    = (op_q == OpInt);
  assign cur_rs    = (op_q == OpData) || is_int;

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= DigitW'(5)) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + DigitW'(3);
      end else begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    priority if (is_int) begin
      cur_byte = neg_q ? AsciiMinus : (AsciiZero + {4'b0, top_digit});
    end else if (op_q == OpInit) begin
      cur_byte = init_byte(idx_q);
    end else begin
      cur_byte = byte_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op_ok      = (op_i <= OpInit);
    sts_o.op_is_int  = (op_i == OpInt);
    sts_o.conv_done  = (bitcnt_q == BitCntW'(NumW - 1));
    sts_o.strip_more = (top_digit == '0) && (ndig_q != 4'd1);
    if (is_int) begin
      sts_o.last_byte = !neg_q && (ndig_q == 4'd1);
    end else if (op_q == OpInit) begin
      sts_o.last_byte = (idx_q == 2'(InitLen - 1));
    end else begin
      sts_o.last_byte = 1'b1;
    end
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      byte_q   <= (op_i == OpCursor) ? (row_base(row_i) + {3'b0, column_i}) : byte_value_i;
      neg_q    <= number_i[NumW-1];
      bin_q    <= number_i[NumW-1] ? (NumW'(0) - $unsigned(number_i)) : $unsigned(number_i);
      bcd_q    <= '0;
      bitcnt_q <= '0;
      ndig_q   <= 4'(NumDigits);
      idx_q    <= '0;
    end else if (cmd_i.conv) begin
      bcd_q    <= {bcd_adj[BcdW-2:0], bin_q[NumW-1]};
      bin_q    <= {bin_q[NumW-2:0], 1'b0};
      bitcnt_q <= bitcnt_q + BitCntW'(1);
    end else if (cmd_i.strip) begin
      bcd_q  <= {bcd_q[BcdW-DigitW-1:0], DigitW'(0)};
      ndig_q <= ndig_q - 4'd1;
    end else if (cmd_i.push_lo) begin
      if (is_int) begin
        if (neg_q) begin
          neg_q <= 1'b0;
        end else begin
          bcd_q  <= {bcd_q[BcdW-DigitW-1:0], DigitW'(0)};
          ndig_q <= ndig_q - 4'd1;
        end
      end
      if (op_q == OpInit) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_hi) begin
      nibble_q <= cur_byte[7:4];
      rs_q     <= cur_rs;
      last_q   <= 1'b0;
    end else if (cmd_i.push_lo) begin
      nibble_q <= cur_byte[3:0];
      rs_q     <= cur_rs;
      last_q   <= sts_o.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_hi || cmd_i.push_lo) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign nibble_o     = nibble_q;
  assign reg_select_o = rs_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

FILE: hdl/char_lcd_nibble_writer_core.sv
// Top level of the 4-bit character-LCD nibble writer.
`default_nettype none

// Turns each request into 4-bit LCD bus words (nibble, register select, last),
// high nibble of every byte first, one word per cycle when the output is not
// stalled. Ops: command byte, data byte, cursor move (row base plus column,
// wrapping to 8 bits), signed 32-bit integer printed as an optional '-' and
// decimal ASCII without leading zeros, and init (clear, display on, shift).
// Undefined ops are accepted and dropped with no words. One request is worked
// at a time. An integer first runs a bit-serial binary-to-BCD converter over
// all 32 input bits, then checks the top digit once per cycle and drops each
// leading zero, then emits each character as a high and a low nibble word.
// Output stalls lengthen a request. The output word register frees the
// input side as soon as the final word is loaded, so a new request is taken
// while that word still waits downstream.

module char_lcd_nibble_writer_core import clnw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [7:0]         byte_value_i,
  input  logic [1:0]         row_i,
  input  logic [4:0]         column_i,
  input  logic signed [31:0] number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         nibble_o,
  output logic               reg_select_o,
  output logic               last_o
);

  clnw_cmd_t cmd;
  clnw_sts_t sts;

  // sequencer: hold the input off while a request is in progress
  clnw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: capture, convert, select the byte and drive the word register
  clnw_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .number_i     (number_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .nibble_o     (nibble_o),
    .reg_select_o (reg_select_o),
    .last_o       (last_o)
  );

`ifndef ASSERT_OFF
  // a defined request keeps the input side closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i <= OpInit) |=> in_stall_o)
    else $error("input not held after accepting a request");

  // a pending word that is not the final one means its request is still running
  a_mid_request_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input reopened before final word");

  // an undefined op produces no work
  a_drop_bad_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i > OpInit) |=> !in_stall_o)
    else $error("undefined op started a request");
`endif

endmodule

`default_nettype wire
